// ----- src/period_average_touch_detect_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for period_average_touch_detect
// Implication checks on the rising clock edge, masked during reset.
// ---------------------------------------------------------------------------
`ifndef PERIOD_AVERAGE_TOUCH_DETECT_MACROS_SVH
`define PERIOD_AVERAGE_TOUCH_DETECT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define PAT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define PAT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PAT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PAT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/pat_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pat_pkg
// Types, codes and reset values shared by the touch detector.
// ---------------------------------------------------------------------------
package pat_pkg;

    localparam int WINDOW_SIZE_DEF = 200;

    localparam logic [15:0] HIGH_THR_RST = 16'd120;
    localparam logic [15:0] LOW_THR_RST  = 16'd80;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    localparam int          CFG_IDX_W    = 8;
    localparam logic [7:0]  CFG_HIGH_THR = 8'd0;
    localparam logic [7:0]  CFG_LOW_THR  = 8'd1;

    typedef struct packed {
        logic        command;
        logic [31:0] edge_time;
    } pat_in_t;

    typedef struct packed {
        logic        touched;
        logic [31:0] average_period;
    } pat_out_t;

    // Quotient estimate and the flag that says it is one short.
    typedef struct packed {
        logic [31:0] quot;
        logic        round_up;
    } pat_div_res_t;

endpackage

// ----- src/pat_window_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pat_window_ram
// Period window store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module pat_window_ram #(
    parameter int DEPTH  = pat_pkg::WINDOW_SIZE_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/pat_div_const.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pat_div_const
// Three-stage division of a 32-bit sum by a constant via reciprocal.
// ---------------------------------------------------------------------------
module pat_div_const #(
    parameter int DIVISOR = pat_pkg::WINDOW_SIZE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          in_sum,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pat_pkg::pat_div_res_t out_res
);

    // floor(2^32 / DIVISOR): the estimate is the true quotient or one below it
    localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(DIVISOR);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic [31:0] DIV_W      = 32'(DIVISOR);

    logic        v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic        en1, en2, en3;
    logic [31:0] q1_reg, sum1_reg, q2_reg, sum2_reg, qw2_reg, q3_reg;
    logic        up3_reg;
    logic [63:0] prod1, prod2;
    logic [31:0] rem2;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign v1_next = en1 ? in_valid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;

    assign prod1 = 64'(in_sum) * 64'(RECIP);
    assign prod2 = 64'(q1_reg) * 64'(DIV_W);
    assign rem2  = sum2_reg - qw2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            q1_reg   <= prod1[63:32];
            sum1_reg <= in_sum;
        end
        if (en2) begin
            q2_reg   <= q1_reg;
            sum2_reg <= sum1_reg;
            qw2_reg  <= prod2[31:0];
        end
        if (en3) begin
            q3_reg  <= q2_reg;
            up3_reg <= (rem2 >= DIV_W);
        end
    end

    assign in_ready         = en1;
    assign out_valid        = v3_reg;
    assign out_res.quot     = q3_reg;
    assign out_res.round_up = up3_reg;

endmodule

// ----- src/period_average_touch_detect.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// period_average_touch_detect
// Capacitive touch detector: edge period, boxcar average, hysteresis.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  s_      | in  | s_valid / s_ready   | pat_in_t  {command, edge_time}
//  m_      | out | m_valid / m_ready   | pat_out_t {touched, average_period}
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (16 bit)
//
//  One item per cycle is taken while the output side keeps up; the window
//  RAM does one read and one write each cycle, which sets that rate.
//  A poll's result passes through the window read, then the running-sum
//  update with the first of three division stages, two more division
//  stages, then the output register.
//  Edge items only update the period registers and produce no result.
//  Reset needs no clearing pass: a wrap flag masks window entries not yet
//  written, so the block is ready as soon as reset is released.
//  Stalls on m_ready back up stage by stage; empty stages keep taking items.
//
`include "period_average_touch_detect_macros.svh"

module period_average_touch_detect #(
    parameter int WINDOW_SIZE = pat_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pat_pkg::pat_in_t                    s_data,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output pat_pkg::pat_out_t                   m_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pat_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam int              PTR_W    = $clog2(WINDOW_SIZE);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SIZE - 1);

    // configuration
    logic [15:0] high_reg, low_reg;
    logic        cfg_we;

    // edge tracking and window bookkeeping
    logic [31:0]      last_edge_reg, latest_period_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             wrapped_reg;
    logic [31:0]      running_sum_reg, sum_next;
    logic [15:0]      thr_reg;

    // stage 1: window read in flight
    logic             s1_valid_reg, s1_valid_next;
    logic [31:0]      s1_period_reg;
    logic             s1_old_ok_reg;
    logic [PTR_W-1:0] s1_slot_reg;
    logic [31:0]      old_entry;

    // handshakes
    logic s_acc, poll_acc, edge_acc, s1_adv;
    logic div_in_ready, div_valid, out_free, out_load;
    pat_pkg::pat_div_res_t div_res;

    // result
    logic              m_valid_reg;
    pat_pkg::pat_out_t m_data_reg;
    logic              hit;
    logic [31:0]       avg;

    // ---------------------------------------------------------------- config
    // Take writes at any time; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg <= pat_pkg::HIGH_THR_RST;
            low_reg  <= pat_pkg::LOW_THR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pat_pkg::CFG_HIGH_THR: high_reg <= cfg_data;
                pat_pkg::CFG_LOW_THR:  low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ acceptance
    // Stage 1 frees up when it is empty or hands its item on.
    assign s1_adv   = s1_valid_reg && div_in_ready;
    assign s_ready  = !s1_valid_reg || div_in_ready;
    assign s_acc    = s_valid && s_ready;
    assign poll_acc = s_acc && (s_data.command == pat_pkg::CMD_POLL);
    assign edge_acc = s_acc && (s_data.command == pat_pkg::CMD_EDGE);

    // Advance the window pointer on every poll; note the first wrap.
    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;

    assign s1_valid_next = poll_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_reg     <= '0;
            latest_period_reg <= '0;
            ptr_reg           <= '0;
            wrapped_reg       <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (edge_acc) begin
                // period wraps modulo 2^32 with the timestamp
                latest_period_reg <= s_data.edge_time - last_edge_reg;
                last_edge_reg     <= s_data.edge_time;
            end
            if (poll_acc) begin
                ptr_reg <= ptr_next;
                if (ptr_reg == PTR_LAST) begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    // Capture the period and slot now, so later edges cannot disturb them.
    always_ff @(posedge aclk) begin
        if (poll_acc) begin
            s1_period_reg <= latest_period_reg;
            s1_slot_reg   <= ptr_reg;
            s1_old_ok_reg <= wrapped_reg;
        end
    end

    // ---------------------------------------------------------------- window
    // Read the oldest entry on acceptance; write the new period back as the
    // item leaves stage 1. Back-to-back polls always touch different slots.
    pat_window_ram #(
        .DEPTH  (WINDOW_SIZE),
        .ADDR_W (PTR_W)
    ) u_window (
        .aclk    (aclk),
        .rd_en   (poll_acc),
        .rd_addr (ptr_reg),
        .rd_data (old_entry),
        .wr_en   (s1_adv),
        .wr_addr (s1_slot_reg),
        .wr_data (s1_period_reg)
    );

    // Entries never written count as zero until the pointer first wraps.
    assign sum_next = running_sum_reg - (s1_old_ok_reg ? old_entry : 32'd0) + s1_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
        end else if (s1_adv) begin
            running_sum_reg <= sum_next;
        end
    end

    // -------------------------------------------------------------- division
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = div_valid && out_free;

    pat_div_const #(
        .DIVISOR (WINDOW_SIZE)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (div_in_ready),
        .in_sum    (sum_next),
        .out_valid (div_valid),
        .out_ready (out_free),
        .out_res   (div_res)
    );

    // -------------------------------------------------------------- decision
    // q+1 > thr is the same test as q >= thr, so both run side by side.
    assign avg = div_res.quot + 32'(div_res.round_up);
    assign hit = div_res.round_up ? (div_res.quot >= 32'(thr_reg))
                                  : (div_res.quot >  32'(thr_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            thr_reg     <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                // hysteresis: drop to the low threshold after a touch
                thr_reg     <= hit ? low_reg : high_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.touched        <= hit;
            m_data_reg.average_period <= avg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------ assertions
    `PAT_ASSERT_NXT(a_wrap_sticky, aclk, aresetn, wrapped_reg, wrapped_reg)
    `PAT_ASSERT_NXT(a_poll_slot, aclk, aresetn, poll_acc, s1_valid_reg && (s1_slot_reg == $past(ptr_reg)))
    `PAT_ASSERT_NXT(a_thr_hold, aclk, aresetn, !out_load, $stable(thr_reg))

endmodule
